/* rtl/filtered_sample_splat_accumulator_core_macros.svh */
// assertion macros for the splat accumulator core
// used by the top level only, no other dependencies
`ifndef FILTERED_SAMPLE_SPLAT_ACCUMULATOR_CORE_MACROS_SVH
`define FILTERED_SAMPLE_SPLAT_ACCUMULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FSSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define FSSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FSSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/fssa_pkg.sv */
// shared types, widths and codes of the splat accumulator core
// no dependencies
package fssa_pkg;

    localparam int TILE_MAX_DEF    = 32;
    localparam int MAX_BORDER_DEF  = 2;
    localparam int TABLE_STEPS_DEF = 16;

    localparam int OFF_W   = 12;
    localparam int RAD_W   = 14;
    localparam int BRD_W   = 2;
    localparam int LF_W    = 20;
    localparam int TSZ_W   = 6;
    localparam int POS_W   = 20;
    localparam int VAL_W   = 25;
    localparam int TI_W    = 4;
    localparam int TV_W    = 16;
    localparam int PIX_W   = 6;
    localparam int SUM_W   = 48;
    localparam int CRD_W   = 7;
    localparam int P8_W    = 23;
    localparam int S_TD_W  = 152;
    localparam int M_TD_W  = 4 * SUM_W;
    localparam int TU_W    = 2;
    localparam int QDEPTH  = 2;

    localparam logic [1:0] FN_SPLAT = 2'd0;
    localparam logic [1:0] FN_TWR   = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_REJ   = 2'd1;
    localparam logic [1:0] ST_TWR   = 2'd2;
    localparam logic [1:0] ST_PIX   = 2'd3;

    localparam logic [1:0] K_SPLAT  = 2'd0;
    localparam logic [1:0] K_REJECT = 2'd1;
    localparam logic [1:0] K_TWR    = 2'd2;
    localparam logic [1:0] K_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    empty;
        logic [CRD_W-1:0]        x0;
        logic [CRD_W-1:0]        x1;
        logic [CRD_W-1:0]        y0;
        logic [CRD_W-1:0]        y1;
        logic signed [P8_W-1:0]  px;
        logic signed [P8_W-1:0]  py;
        logic signed [VAL_W-1:0] vr;
        logic signed [VAL_W-1:0] vg;
        logic signed [VAL_W-1:0] vb;
        logic [TI_W-1:0]         tidx;
        logic signed [TV_W-1:0]  tval;
        logic [PIX_W-1:0]        col;
        logic [PIX_W-1:0]        row;
        logic                    oob;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_bk_stat;

endpackage

/* rtl/fssa_front.sv */
// front end: accepts stream transactions, classifies them and computes footprints
// depends on fssa_pkg
module fssa_front #(
    parameter int TILE_MAX   = fssa_pkg::TILE_MAX_DEF,
    parameter int MAX_BORDER = fssa_pkg::MAX_BORDER_DEF,
    parameter int STORE_DIM  = TILE_MAX + 2 * MAX_BORDER
) (
    input  logic                         i_valid,
    input  logic [fssa_pkg::S_TD_W-1:0]  i_data,
    input  logic [fssa_pkg::TU_W-1:0]    i_user,
    input  logic                         i_clearing,
    input  logic                         i_q_ready,
    input  logic [fssa_pkg::OFF_W-1:0]   i_off_x,
    input  logic [fssa_pkg::OFF_W-1:0]   i_off_y,
    input  logic [fssa_pkg::RAD_W-1:0]   i_radius,
    input  logic [fssa_pkg::BRD_W-1:0]   i_border,
    input  logic [fssa_pkg::TSZ_W-1:0]   i_tile_w,
    input  logic [fssa_pkg::TSZ_W-1:0]   i_tile_h,
    output logic                         o_ready,
    output logic                         o_push,
    output fssa_pkg::t_cmd               o_cmd
);
    import fssa_pkg::*;

    typedef struct packed {
        logic [CRD_W-1:0]       lo;
        logic [CRD_W-1:0]       hi;
        logic                   empty;
        logic signed [P8_W-1:0] p8;
    } t_axis;

    function automatic t_axis axis_fn(input logic [POS_W-1:0] pos,
                                      input logic [OFF_W-1:0] off,
                                      input logic [BRD_W-1:0] brd,
                                      input logic [RAD_W-1:0] rad,
                                      input logic signed [16:0] ext_m1);
        t_axis                  a;
        logic signed [P8_W-1:0] p8;
        logic signed [27:0]     s28;
        logic signed [27:0]     r28;
        logic signed [27:0]     hs;
        logic signed [27:0]     ls;
        logic signed [16:0]     lo;
        logic signed [16:0]     hi;
        p8  = $signed({3'b000, pos}) - 23'sd128 - $signed({3'b000, off, 8'h00})
              + $signed({13'd0, brd, 8'h00});
        s28 = $signed({p8[P8_W-1], p8, 4'h0});
        r28 = $signed({14'd0, rad});
        hs  = s28 + r28;
        ls  = r28 - s28;
        // floor via arithmetic shift, ceil as minus floor of the negation
        hi  = $signed({hs[27], hs[27:12]});
        lo  = -$signed({ls[27], ls[27:12]});
        if (lo < 17'sd0) begin
            lo = 17'sd0;
        end
        if (hi > ext_m1) begin
            hi = ext_m1;
        end
        a.empty = (lo > hi);
        a.lo    = lo[CRD_W-1:0];
        a.hi    = hi[CRD_W-1:0];
        a.p8    = p8;
        return a;
    endfunction

    logic [1:0]              func;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VAL_W-1:0] vr;
    logic signed [VAL_W-1:0] vg;
    logic signed [VAL_W-1:0] vb;
    logic [BRD_W-1:0]        brd_s;
    logic [TSZ_W-1:0]        tw_s;
    logic [TSZ_W-1:0]        th_s;
    logic signed [16:0]      extx_m1;
    logic signed [16:0]      exty_m1;
    t_axis                   ax;
    t_axis                   ay;

    assign func  = i_user[1:0];
    assign pos_x = i_data[19:0];
    assign pos_y = i_data[39:20];
    assign vr    = $signed(i_data[64:40]);
    assign vg    = $signed(i_data[89:65]);
    assign vb    = $signed(i_data[114:90]);

    assign brd_s = (32'(i_border) > MAX_BORDER) ? BRD_W'(MAX_BORDER) : i_border;
    assign tw_s  = (32'(i_tile_w) > TILE_MAX) ? TSZ_W'(TILE_MAX) : i_tile_w;
    assign th_s  = (32'(i_tile_h) > TILE_MAX) ? TSZ_W'(TILE_MAX) : i_tile_h;

    assign extx_m1 = $signed(17'(tw_s)) + $signed(17'({brd_s, 1'b0})) - 17'sd1;
    assign exty_m1 = $signed(17'(th_s)) + $signed(17'({brd_s, 1'b0})) - 17'sd1;

    assign ax = axis_fn(pos_x, i_off_x, brd_s, i_radius, extx_m1);
    assign ay = axis_fn(pos_y, i_off_y, brd_s, i_radius, exty_m1);

    assign o_ready = !i_clearing && i_q_ready;
    // unused function code is taken and dropped
    assign o_push  = i_valid && o_ready && (func != 2'd3);

    always_comb begin
        o_cmd       = '0;
        o_cmd.empty = ax.empty || ay.empty;
        o_cmd.x0    = ax.lo;
        o_cmd.x1    = ax.hi;
        o_cmd.y0    = ay.lo;
        o_cmd.y1    = ay.hi;
        o_cmd.px    = ax.p8;
        o_cmd.py    = ay.p8;
        o_cmd.vr    = vr;
        o_cmd.vg    = vg;
        o_cmd.vb    = vb;
        o_cmd.tidx  = i_data[118:115];
        o_cmd.tval  = $signed(i_data[134:119]);
        o_cmd.col   = i_data[140:135];
        o_cmd.row   = i_data[146:141];
        o_cmd.oob   = (32'(i_data[140:135]) >= STORE_DIM) ||
                      (32'(i_data[146:141]) >= STORE_DIM);
        unique case (func)
            FN_SPLAT: o_cmd.kind = (vr < 0 || vg < 0 || vb < 0) ? K_REJECT : K_SPLAT;
            FN_TWR:   o_cmd.kind = K_TWR;
            FN_READ:  o_cmd.kind = K_READ;
            default:  o_cmd.kind = K_READ;
        endcase
    end

endmodule

/* rtl/fssa_queue.sv */
// command queue between front end and back end
// depends on fssa_pkg
module fssa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fssa_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output fssa_pkg::t_cmd o_cmd
);
    import fssa_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_ready = (32'(r_cnt) < QDEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/fssa_back.sv */
// back end: filter table, pixel store, per-pixel read-modify-write sequencer, result register
// depends on fssa_pkg
module fssa_back #(
    parameter int TILE_MAX    = fssa_pkg::TILE_MAX_DEF,
    parameter int MAX_BORDER  = fssa_pkg::MAX_BORDER_DEF,
    parameter int TABLE_STEPS = fssa_pkg::TABLE_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  fssa_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    input  logic [fssa_pkg::LF_W-1:0]   i_lf,
    output fssa_pkg::t_bk_stat          o_stat,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fssa_pkg::M_TD_W-1:0] o_data,
    output logic [fssa_pkg::TU_W-1:0]   o_user
);
    import fssa_pkg::*;

    localparam int SD    = TILE_MAX + 2 * MAX_BORDER;
    localparam int DEPTH = SD * SD;
    localparam int AW    = $clog2(DEPTH);
    localparam int TIW   = $clog2(TABLE_STEPS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ROW0 = 4'd2;
    localparam logic [3:0] S_ROW1 = 4'd3;
    localparam logic [3:0] S_PX0  = 4'd4;
    localparam logic [3:0] S_PX1  = 4'd5;
    localparam logic [3:0] S_PX2  = 4'd6;
    localparam logic [3:0] S_PX3  = 4'd7;
    localparam logic [3:0] S_RD0  = 4'd8;
    localparam logic [3:0] S_RD1  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    function automatic logic signed [SUM_W-1:0] add_sat(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] d);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {d[SUM_W-1], d};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    logic [3:0]               r_state;
    logic [AW-1:0]            r_caddr;
    t_cmd                     r_cmd;
    logic [CRD_W-1:0]         r_x;
    logic [CRD_W-1:0]         r_y;
    logic [30:0]              r_prod;
    logic signed [TV_W-1:0]   r_wy;
    logic signed [31:0]       r_w;
    logic signed [56:0]       r_pr;
    logic signed [56:0]       r_pg;
    logic signed [56:0]       r_pb;
    logic signed [25:0]       r_ww;
    logic [AW-1:0]            r_addr;
    logic [M_TD_W-1:0]        r_rdata;
    logic [M_TD_W-1:0]        r_sums;
    logic [1:0]               r_status;
    logic                     r_ovalid;
    logic [M_TD_W-1:0]        r_odata;
    logic [1:0]               r_ouser;
    logic signed [TV_W-1:0]   r_tbl [TABLE_STEPS];
    logic [M_TD_W-1:0]        r_mem [DEPTH];

    logic [CRD_W-1:0]         c_crd;
    logic signed [P8_W-1:0]   c_p;
    logic signed [23:0]       c_dd;
    logic [23:0]              c_ad;
    logic [10:0]              c_d;
    logic [10:0]              c_idx;
    logic signed [TV_W-1:0]   c_tv;
    logic [AW-1:0]            c_raddr;
    logic                     c_re;
    logic                     c_we;
    logic [AW-1:0]            c_waddr;
    logic [M_TD_W-1:0]        c_wdata;
    logic [M_TD_W-1:0]        c_new;
    logic [TIW-1:0]           c_twi;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;

    // distance to sample, table index through the shared multiplier
    assign c_crd = (r_state == S_ROW0) ? r_y : r_x;
    assign c_p   = (r_state == S_ROW0) ? r_cmd.py : r_cmd.px;
    assign c_dd  = $signed(24'({c_crd, 8'h00})) - 24'(c_p);
    assign c_ad  = c_dd[23] ? 24'(-c_dd) : 24'(c_dd);
    assign c_d   = (c_ad > 24'd2047) ? 11'h7ff : c_ad[10:0];
    assign c_idx = r_prod[30:20];
    assign c_tv  = (32'(c_idx) >= TABLE_STEPS) ? '0 : r_tbl[c_idx[TIW-1:0]];
    assign c_twi = TIW'(i_q_cmd.tidx);

    always_comb begin
        c_new[SUM_W-1:0]         = add_sat(r_rdata[SUM_W-1:0], SUM_W'(r_pr >>> 22));
        c_new[2*SUM_W-1:SUM_W]   = add_sat(r_rdata[2*SUM_W-1:SUM_W], SUM_W'(r_pg >>> 22));
        c_new[3*SUM_W-1:2*SUM_W] = add_sat(r_rdata[3*SUM_W-1:2*SUM_W], SUM_W'(r_pb >>> 22));
        c_new[4*SUM_W-1:3*SUM_W] = add_sat(r_rdata[4*SUM_W-1:3*SUM_W], SUM_W'(r_ww));
    end

    always_comb begin
        c_re    = 1'b0;
        c_raddr = AW'(r_y) * AW'(SD) + AW'(r_x);
        if (r_state == S_PX0) begin
            c_re = 1'b1;
        end else if (r_state == S_RD0) begin
            c_re    = 1'b1;
            c_raddr = AW'(r_cmd.row) * AW'(SD) + AW'(r_cmd.col);
        end
        c_we    = 1'b0;
        c_waddr = r_addr;
        c_wdata = c_new;
        if (r_state == S_CLR) begin
            c_we    = 1'b1;
            c_waddr = r_caddr;
            c_wdata = '0;
        end else if (r_state == S_PX3) begin
            c_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_rdata <= r_mem[c_raddr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROW0 || r_state == S_PX0) begin
            r_prod <= 31'(c_d) * 31'(i_lf);
        end
        if (r_state == S_ROW1) begin
            r_wy <= c_tv;
        end
        if (r_state == S_PX0) begin
            r_addr <= c_raddr;
        end
        if (r_state == S_PX1) begin
            r_w <= 32'(c_tv) * 32'(r_wy);
        end
        if (r_state == S_PX2) begin
            r_pr <= 57'(r_cmd.vr) * 57'(r_w);
            r_pg <= 57'(r_cmd.vg) * 57'(r_w);
            r_pb <= 57'(r_cmd.vb) * 57'(r_w);
            r_ww <= 26'(r_w >>> 6);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_caddr  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < TABLE_STEPS; i++) begin
                r_tbl[i] <= '0;
            end
        end else begin
            // a result loaded in S_OUT takes the place of the one leaving
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (32'(r_caddr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd  <= i_q_cmd;
                        r_sums <= '0;
                        r_x    <= i_q_cmd.x0;
                        r_y    <= i_q_cmd.y0;
                        unique case (i_q_cmd.kind)
                            K_SPLAT: begin
                                r_status <= ST_DONE;
                                r_state  <= i_q_cmd.empty ? S_OUT : S_ROW0;
                            end
                            K_REJECT: begin
                                r_status <= ST_REJ;
                                r_state  <= S_OUT;
                            end
                            K_TWR: begin
                                if (32'(i_q_cmd.tidx) < TABLE_STEPS) begin
                                    r_tbl[c_twi] <= i_q_cmd.tval;
                                end
                                r_status <= ST_TWR;
                                r_state  <= S_OUT;
                            end
                            K_READ: begin
                                r_status <= ST_PIX;
                                r_state  <= i_q_cmd.oob ? S_OUT : S_RD0;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_ROW0: r_state <= S_ROW1;
                S_ROW1: r_state <= S_PX0;
                S_PX0:  r_state <= S_PX1;
                S_PX1:  r_state <= S_PX2;
                S_PX2:  r_state <= S_PX3;
                S_PX3: begin
                    if (r_x == r_cmd.x1) begin
                        r_x <= r_cmd.x0;
                        if (r_y == r_cmd.y1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_state <= S_ROW0;
                        end
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_PX0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_sums  <= r_rdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_sums;
                        r_ouser  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/filtered_sample_splat_accumulator_core.sv */
// top level of the splat accumulator core: config registers, front end, queue, back end
// depends on fssa_pkg, fssa_front, fssa_queue, fssa_back and the assertion macro header
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata operands, s_tuser function code
// m_*       out        m_tvalid/m_tready  m_tdata pixel sums, m_tuser status
// apb       in/out     psel/penable       paddr, pwdata, prdata
//
// a splat in the back end steps through S_ROW0 and S_ROW1 for each row and S_PX0 to S_PX3 for each pixel,
// the read-modify-write of one pixel in the store
// table writes, rejects and out-of-store reads go from S_IDLE straight to S_OUT, pixel reads pass S_RD0 and S_RD1
// after reset a clearing pass writes all 1296 store words (one per cycle) and s_tready stays low
// the two-entry queue and the output register let either side stall on its own
`include "filtered_sample_splat_accumulator_core_macros.svh"

module filtered_sample_splat_accumulator_core #(
    parameter int TILE_MAX    = fssa_pkg::TILE_MAX_DEF,
    parameter int MAX_BORDER  = fssa_pkg::MAX_BORDER_DEF,
    parameter int TABLE_STEPS = fssa_pkg::TABLE_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, value_r, value_g, value_b, table_index, table_value, pixel_col, pixel_row
    input  logic [fssa_pkg::S_TD_W-1:0] s_tdata,
    // func
    input  logic [fssa_pkg::TU_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // sum_r, sum_g, sum_b, sum_weight
    output logic [fssa_pkg::M_TD_W-1:0] m_tdata,
    // status
    output logic [fssa_pkg::TU_W-1:0]   m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fssa_pkg::*;

    localparam logic [2:0] R_OFF_X  = 3'd0;
    localparam logic [2:0] R_OFF_Y  = 3'd1;
    localparam logic [2:0] R_RADIUS = 3'd2;
    localparam logic [2:0] R_BORDER = 3'd3;
    localparam logic [2:0] R_LF     = 3'd4;
    localparam logic [2:0] R_TILE_W = 3'd5;
    localparam logic [2:0] R_TILE_H = 3'd6;

    logic [OFF_W-1:0] r_off_x;
    logic [OFF_W-1:0] r_off_y;
    logic [RAD_W-1:0] r_radius;
    logic [BRD_W-1:0] r_border;
    logic [LF_W-1:0]  r_lf;
    logic [TSZ_W-1:0] r_tile_w;
    logic [TSZ_W-1:0] r_tile_h;

    logic     cfg_wr;
    logic     q_push;
    logic     q_ready;
    logic     q_pop;
    logic     q_valid;
    t_cmd     f_cmd;
    t_cmd     q_cmd;
    t_bk_stat bk_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_radius <= RAD_W'(2048);
            r_border <= '0;
            r_lf     <= LF_W'(131072);
            r_tile_w <= TSZ_W'(32);
            r_tile_h <= TSZ_W'(32);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                R_OFF_X:  r_off_x  <= pwdata[OFF_W-1:0];
                R_OFF_Y:  r_off_y  <= pwdata[OFF_W-1:0];
                R_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                R_BORDER: r_border <= pwdata[BRD_W-1:0];
                R_LF:     r_lf     <= pwdata[LF_W-1:0];
                R_TILE_W: r_tile_w <= pwdata[TSZ_W-1:0];
                R_TILE_H: r_tile_h <= pwdata[TSZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            R_OFF_X:  prdata = 32'(r_off_x);
            R_OFF_Y:  prdata = 32'(r_off_y);
            R_RADIUS: prdata = 32'(r_radius);
            R_BORDER: prdata = 32'(r_border);
            R_LF:     prdata = 32'(r_lf);
            R_TILE_W: prdata = 32'(r_tile_w);
            R_TILE_H: prdata = 32'(r_tile_h);
            default:  prdata = '0;
        endcase
    end

    fssa_front #(
        .TILE_MAX   (TILE_MAX),
        .MAX_BORDER (MAX_BORDER)
    ) u_front (
        .i_valid    (s_tvalid),
        .i_data     (s_tdata),
        .i_user     (s_tuser),
        .i_clearing (bk_stat.clearing),
        .i_q_ready  (q_ready),
        .i_off_x    (r_off_x),
        .i_off_y    (r_off_y),
        .i_radius   (r_radius),
        .i_border   (r_border),
        .i_tile_w   (r_tile_w),
        .i_tile_h   (r_tile_h),
        .o_ready    (s_tready),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    fssa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    fssa_back #(
        .TILE_MAX    (TILE_MAX),
        .MAX_BORDER  (MAX_BORDER),
        .TABLE_STEPS (TABLE_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .i_lf      (r_lf),
        .o_stat    (bk_stat),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_data    (m_tdata),
        .o_user    (m_tuser)
    );

    `FSSA_ASSERT_IMP(a_push_room, i_clk, i_rst_n, q_push, q_ready, "push into full queue")
    `FSSA_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, q_pop, q_valid, "pop from empty queue")
    `FSSA_ASSERT_IMP(a_no_out_clr, i_clk, i_rst_n, m_tvalid, !bk_stat.clearing, "result in clear")
    `FSSA_ASSERT_NXT(a_pop_busy, i_clk, i_rst_n, q_pop, !bk_stat.idle, "back idle after pop")

endmodule
